>>> rtl/pq_pkg.sv
// Shared types, constants and character tables for the proquint codec.
package pq_pkg;

    localparam int PQ_LEN = 11;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef logic [3:0] pos_t;

    localparam pos_t DASH_POS = 4'd5;
    localparam pos_t LAST_POS = 4'(PQ_LEN - 1);
    localparam pos_t POS_FULL = 4'(PQ_LEN);

    localparam logic [7:0] DASH_CHAR = 8'h2d;

    localparam logic [7:0] CONS_TAB [16] = '{
        8'h62, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c,
        8'h6d, 8'h6e, 8'h70, 8'h72, 8'h73, 8'h74, 8'h76, 8'h7a
    };
    localparam logic [7:0] VOW_TAB [4] = '{8'h61, 8'h69, 8'h6f, 8'h75};

    typedef struct packed {
        logic        func;
        logic [31:0] word_in;
        logic [7:0]  char_in;
        logic        end_of_string;
    } in_beat_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_out;
        logic        last_char;
        logic [31:0] word_out;
        logic        decode_ok;
    } out_beat_t;

    typedef struct packed {
        logic        is_decode;
        logic [31:0] word;
        logic        ok;
    } job_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } cons_hit_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } vow_hit_t;

    function automatic cons_hit_t cons_lookup(logic [7:0] ch);
        cons_hit_t r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (CONS_TAB[i] == ch) begin
                r.hit = 1'b1;
                r.idx = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic vow_hit_t vow_lookup(logic [7:0] ch);
        vow_hit_t r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            if (VOW_TAB[i] == ch) begin
                r.hit = 1'b1;
                r.idx = 2'(i);
            end
        end
        return r;
    endfunction

    function automatic logic is_vowel_pos(pos_t p);
        return (p == 4'd1) || (p == 4'd3) || (p == 4'd7) || (p == 4'd9);
    endfunction

    function automatic logic [7:0] enc_char(logic [31:0] w, pos_t idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CONS_TAB[w[31:28]];
            4'd1:    c = VOW_TAB[w[27:26]];
            4'd2:    c = CONS_TAB[w[25:22]];
            4'd3:    c = VOW_TAB[w[21:20]];
            4'd4:    c = CONS_TAB[w[19:16]];
            4'd5:    c = DASH_CHAR;
            4'd6:    c = CONS_TAB[w[15:12]];
            4'd7:    c = VOW_TAB[w[11:10]];
            4'd8:    c = CONS_TAB[w[9:6]];
            4'd9:    c = VOW_TAB[w[5:4]];
            4'd10:   c = CONS_TAB[w[3:0]];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/pq_fifo.sv
// Short job queue between the front and back parts of the proquint codec.
module pq_fifo #(
    parameter int DEPTH = pq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pq_pkg::job_t  push_job,
    input  logic          pop,
    output pq_pkg::job_t  head,
    output logic          full,
    output logic          empty
);
    import pq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("Job pushed into a full queue.");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("Job popped from an empty queue.");

endmodule

>>> rtl/pq_front.sv
// Front part: accepts input beats, checks and gathers decode characters, queues jobs.
module pq_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pq_pkg::in_beat_t s_beat,
    input  logic             queue_full,
    output logic             push,
    output pq_pkg::job_t     push_job
);
    import pq_pkg::*;

    pos_t        pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic        bad_reg, bad_next;
    logic        accept;
    cons_hit_t   ch_cons;
    vow_hit_t    ch_vow;
    logic        ok;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign ch_cons = cons_lookup(s_beat.char_in);
    assign ch_vow  = vow_lookup(s_beat.char_in);

    always_comb begin
        pos_next  = pos_reg;
        word_next = word_reg;
        bad_next  = bad_reg;
        push      = 1'b0;
        push_job  = '0;
        ok        = 1'b0;
        if (accept) begin
            if (s_beat.func == FUNC_ENCODE) begin
                push               = 1'b1;
                push_job.is_decode = 1'b0;
                push_job.word      = s_beat.word_in;
            end else begin
                if (pos_reg >= POS_FULL) begin
                    bad_next = 1'b1;
                end else begin
                    if (pos_reg == DASH_POS) begin
                        if (s_beat.char_in != DASH_CHAR) begin
                            bad_next = 1'b1;
                        end
                    end else if (is_vowel_pos(pos_reg)) begin
                        if (!ch_vow.hit) begin
                            bad_next = 1'b1;
                        end
                        word_next = {word_reg[29:0], ch_vow.idx};
                    end else begin
                        if (!ch_cons.hit) begin
                            bad_next = 1'b1;
                        end
                        word_next = {word_reg[27:0], ch_cons.idx};
                    end
                    pos_next = pos_reg + 1'b1;
                end
                if (s_beat.end_of_string) begin
                    ok                 = !bad_next && (pos_next == POS_FULL);
                    push               = 1'b1;
                    push_job.is_decode = 1'b1;
                    push_job.word      = ok ? word_next : 32'd0;
                    push_job.ok        = ok;
                    pos_next           = '0;
                    word_next          = '0;
                    bad_next           = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            word_reg <= '0;
            bad_reg  <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            word_reg <= word_next;
            bad_reg  <= bad_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) pos_reg <= POS_FULL)
        else $error("Character position passed the string length.");

endmodule

>>> rtl/pq_back.sv
// Back part: turns queued jobs into result beats behind an output register.
module pq_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  pq_pkg::job_t      head,
    input  logic              queue_empty,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pq_pkg::out_beat_t m_beat
);
    import pq_pkg::*;

    pos_t      idx_reg, idx_next;
    out_beat_t beat_reg, beat_next;
    logic      valid_reg, valid_next;
    logic      load;
    logic      at_last;

    assign m_valid = valid_reg;
    assign m_beat  = beat_reg;
    assign load    = (!valid_reg || m_ready) && !queue_empty;
    assign at_last = (idx_reg == LAST_POS);

    always_comb begin
        idx_next   = idx_reg;
        beat_next  = beat_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.is_decode) begin
                beat_next.kind      = KIND_DECODE;
                beat_next.char_out  = 8'h00;
                beat_next.last_char = 1'b0;
                beat_next.word_out  = head.word;
                beat_next.decode_ok = head.ok;
                pop                 = 1'b1;
                idx_next            = '0;
            end else begin
                beat_next.kind      = KIND_ENCODE;
                beat_next.char_out  = enc_char(head.word, idx_reg);
                beat_next.last_char = at_last;
                beat_next.word_out  = 32'd0;
                beat_next.decode_ok = 1'b0;
                pop                 = at_last;
                idx_next            = at_last ? '0 : idx_reg + 1'b1;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) idx_reg <= LAST_POS)
        else $error("Character index passed the last character.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && beat_reg.last_char) |-> (beat_reg.kind == KIND_ENCODE))
        else $error("Last-character flag on a decode result.");

endmodule

>>> rtl/proquint_codec_core.sv
// Top level of the proquint codec: front part, job queue and back part.
//
// Input channel s_valid/s_ready/s_beat carries one beat per item. With func
// set to encode, the beat's word becomes eleven result beats, one proquint
// character each, the last one flagged by last_char. With func set to
// decode, the beat carries one character; only the beat marked
// end_of_string yields a result, holding the word and decode_ok.
// Result channel m_valid/m_ready/m_beat carries the results in order.
// An input beat is taken in every cycle while the job queue has room, so
// decode characters stream at one per cycle. Each encode job occupies the
// back part for eleven result beats, one per character; a decode job
// yields one. An input beat's result passes through its queue entry and
// then the output register. The back part's character counter sets the
// encode rate; the queue depth sets how far input may run ahead.
// When the receiver stalls, the output register holds its beat and the
// queue fills; once full, s_ready drops until a job finishes.
// Synchronous reset clears the queue, the output valid and the decode
// position, word and error state, so the next string starts fresh.
module proquint_codec_core #(
    parameter int QUEUE_DEPTH = pq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pq_pkg::in_beat_t  s_beat,
    output logic              m_valid,
    input  logic              m_ready,
    output pq_pkg::out_beat_t m_beat
);
    import pq_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    job_t push_job;
    job_t head;

    pq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    pq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    pq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_beat      (m_beat)
    );

endmodule
